[rtl/nsg_pkg.sv]
// Shared types and constants of the nod and shake gesture detector.
`timescale 1ns / 1ps
`default_nettype none

package nsg_pkg;

    // Field widths of the channels and the configuration port
    localparam int ACC_W      = 12;
    localparam int TICK_W     = 32;
    localparam int MOTION_W   = 2;
    localparam int CROSS_W    = 6;
    localparam int DEADBAND_W = 11;
    localparam int THRESH_W   = 6;
    localparam int HOLD_W     = 16;
    localparam int MIN_FILL_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // A window mean never exceeds 2048 in magnitude.
    localparam int QUO_W      = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FILL  = 2'd3;

    // Reset values of the configuration registers
    localparam logic [DEADBAND_W-1:0] DEADBAND_RST  = 11'd80;
    localparam logic [THRESH_W-1:0]   THRESHOLD_RST = 6'd4;
    localparam logic [HOLD_W-1:0]     HOLD_RST      = 16'd1000;
    localparam logic [MIN_FILL_W-1:0] MIN_FILL_RST  = 7'd6;

    typedef enum logic [MOTION_W-1:0] {
        MOTION_STATIONARY = 2'd0,
        MOTION_NODDING    = 2'd1,
        MOTION_SHAKING    = 2'd2
    } motion_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_SCAN,
        ST_CLASS,
        ST_OUT
    } state_t;

    // Control of one crossing-count lane
    typedef struct packed {
        logic clear;
        logic step;
    } lane_ctl_t;

endpackage

`default_nettype wire

[rtl/nsg_if.sv]
// Stream interfaces for the sample channel and the result channel.
`timescale 1ns / 1ps
`default_nettype none

interface nsg_smp_if;
    import nsg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ACC_W-1:0]  accel_x_mg;
    logic signed [ACC_W-1:0]  accel_y_mg;
    logic        [TICK_W-1:0] now_tick;

    modport source (output valid, output accel_x_mg, output accel_y_mg, output now_tick,
                    input ready);
    modport sink   (input valid, input accel_x_mg, input accel_y_mg, input now_tick,
                    output ready);
endinterface

interface nsg_res_if;
    import nsg_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [MOTION_W-1:0]       motion_state;
    logic [CROSS_W-1:0]        x_crossings;
    logic [CROSS_W-1:0]        y_crossings;

    modport source (output valid, output motion_state, output x_crossings,
                    output y_crossings, input ready);
    modport sink   (input valid, input motion_state, input x_crossings,
                    input y_crossings, output ready);
endinterface

`default_nettype wire

[rtl/nod_shake_gesture_detector_core.sv]
// Top level of the nod and shake gesture detector.
//
// Samples arrive on smp (accel_x_mg, accel_y_mg, now_tick) and each one gives
// exactly one item on res (motion_state, x_crossings, y_crossings). Registers
// are written through cfg_we, cfg_addr and cfg_wdata; the user must write them
// only while the block is idle, which the block itself does not enforce.
//
// A sample is written into the window memory on the cycle it is accepted. If
// the window holds fewer than min_fill samples the result is offered in ST_OUT
// straight after ST_CHECK. Otherwise the block makes one pass over the filled
// slots to form the sums, runs the shared divider twice (once per axis) and
// makes a second pass to count crossings before it offers the result. The
// block takes no new sample until the result of the last one has been taken.
// smp.ready is high only while idle.
//
// The result is held on res until it is taken; a stalled receiver simply
// holds the block. Reset clears the write pointer, fill flag, hold deadline
// and motion state and loads the register defaults. The window memory is not
// cleared; only written slots are ever read.
`timescale 1ns / 1ps
`default_nettype none

module nod_shake_gesture_detector_core #(
    parameter int WINDOW_DEPTH = 20
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    nsg_smp_if.sink                                 smp,
    nsg_res_if.source                               res,
    input  wire logic                               cfg_we,
    input  wire logic [nsg_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [nsg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import nsg_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = ACC_W + 1 + $clog2(WINDOW_DEPTH);
    localparam int CMP_W  = (FILL_W > MIN_FILL_W) ? FILL_W : MIN_FILL_W;
    localparam int WORD_W = 2 * ACC_W;

    // Configuration registers
    logic [DEADBAND_W-1:0]  deadband_reg;
    logic [THRESH_W-1:0]    threshold_reg;
    logic [HOLD_W-1:0]      hold_reg;
    logic [MIN_FILL_W-1:0]  min_fill_reg;

    // Sequencer and window state
    state_t                 state_reg, state_next;
    logic [SLOT_W-1:0]      write_slot_reg;
    logic                   full_reg;
    logic [FILL_W-1:0]      addr_reg;
    logic                   rd_pend_reg;
    motion_t                motion_reg;
    logic [TICK_W-1:0]      deadline_reg;

    // Payload registers
    logic [TICK_W-1:0]      now_reg;
    logic signed [SUM_W-1:0] sum_x_reg;
    logic signed [SUM_W-1:0] sum_y_reg;
    logic signed [QUO_W:0]  mean_x_reg;
    logic signed [QUO_W:0]  mean_y_reg;
    logic [CROSS_W-1:0]     res_x_reg;
    logic [CROSS_W-1:0]     res_y_reg;
    logic [WORD_W-1:0]      rd_data_reg;

    logic [WORD_W-1:0]      win_mem [WINDOW_DEPTH];

    // Sequencer outputs
    logic                   accept;
    logic                   rd_en;
    logic                   div_start;
    logic                   sum_done;
    lane_ctl_t              lane_ctl;

    logic [FILL_W-1:0]      fill;
    logic                   fill_ok;
    logic signed [ACC_W-1:0] rd_x;
    logic signed [ACC_W-1:0] rd_y;
    logic signed [SUM_W-1:0] div_dividend;
    logic                   div_done;
    logic signed [QUO_W:0]  div_quotient;
    logic [CROSS_W-1:0]     x_count;
    logic [CROSS_W-1:0]     y_count;
    logic                   is_nod;
    logic                   is_shake;
    logic [TICK_W-1:0]      since_deadline;

    assign fill    = full_reg ? FILL_W'(WINDOW_DEPTH) : FILL_W'(write_slot_reg);
    assign fill_ok = (CMP_W'(fill) >= CMP_W'(min_fill_reg));
    assign rd_x    = rd_data_reg[WORD_W-1:ACC_W];
    assign rd_y    = rd_data_reg[ACC_W-1:0];
    assign sum_done = !rd_en && !rd_pend_reg;

    assign is_nod   = (y_count >= threshold_reg) && (y_count >= x_count);
    assign is_shake = (x_count >= threshold_reg) && (x_count > y_count);
    assign since_deadline = now_reg - deadline_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (smp.valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = fill_ok ? ST_SUM : ST_OUT;
            end
            ST_SUM:
            begin
                if (sum_done)
                begin
                    state_next = ST_DIVX_GO;
                end
            end
            ST_DIVX_GO:
            begin
                state_next = ST_DIVX_WAIT;
            end
            ST_DIVX_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_DIVY_GO;
                end
            end
            ST_DIVY_GO:
            begin
                state_next = ST_DIVY_WAIT;
            end
            ST_DIVY_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sum_done)
                begin
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (res.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        smp.ready      = (state_reg == ST_IDLE);
        res.valid      = (state_reg == ST_OUT);
        rd_en          = (state_reg inside {ST_SUM, ST_SCAN}) && (addr_reg < fill);
        div_start      = (state_reg inside {ST_DIVX_GO, ST_DIVY_GO});
        lane_ctl.clear = (state_reg == ST_CHECK);
        lane_ctl.step  = (state_reg == ST_SCAN) && rd_pend_reg;
    end

    assign accept       = smp.valid && smp.ready;
    assign div_dividend = (state_reg == ST_DIVY_GO) ? sum_y_reg : sum_x_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg  <= DEADBAND_RST;
            threshold_reg <= THRESHOLD_RST;
            hold_reg      <= HOLD_RST;
            min_fill_reg  <= MIN_FILL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_DEADBAND:  deadband_reg  <= cfg_wdata[DEADBAND_W-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_wdata[THRESH_W-1:0];
                REG_HOLD:      hold_reg      <= cfg_wdata[HOLD_W-1:0];
                REG_MIN_FILL:  min_fill_reg  <= cfg_wdata[MIN_FILL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            write_slot_reg <= '0;
            full_reg       <= 1'b0;
            addr_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            motion_reg     <= MOTION_STATIONARY;
            deadline_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_en;

            if (accept)
            begin
                if (write_slot_reg == SLOT_W'(WINDOW_DEPTH - 1))
                begin
                    write_slot_reg <= '0;
                    full_reg       <= 1'b1;
                end
                else
                begin
                    write_slot_reg <= write_slot_reg + 1'b1;
                end
            end

            if ((state_reg == ST_CHECK) || ((state_reg == ST_DIVY_WAIT) && div_done))
            begin
                addr_reg <= '0;
            end
            else if (rd_en)
            begin
                addr_reg <= addr_reg + 1'b1;
            end

            if (state_reg == ST_CLASS)
            begin
                if (is_nod)
                begin
                    motion_reg   <= MOTION_NODDING;
                    deadline_reg <= now_reg + TICK_W'(hold_reg);
                end
                else if (is_shake)
                begin
                    motion_reg   <= MOTION_SHAKING;
                    deadline_reg <= now_reg + TICK_W'(hold_reg);
                end
                else if (!since_deadline[TICK_W-1])
                begin
                    // The hold has run out, wrap-safe.
                    motion_reg <= MOTION_STATIONARY;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= smp.now_tick;
        end

        if (state_reg == ST_CHECK)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            res_x_reg <= '0;
            res_y_reg <= '0;
        end
        else if ((state_reg == ST_SUM) && rd_pend_reg)
        begin
            sum_x_reg <= sum_x_reg + SUM_W'(rd_x);
            sum_y_reg <= sum_y_reg + SUM_W'(rd_y);
        end

        if ((state_reg == ST_DIVX_WAIT) && div_done)
        begin
            mean_x_reg <= div_quotient;
        end
        if ((state_reg == ST_DIVY_WAIT) && div_done)
        begin
            mean_y_reg <= div_quotient;
        end

        if (state_reg == ST_CLASS)
        begin
            res_x_reg <= x_count;
            res_y_reg <= y_count;
        end
    end

    // Window memory: x in the upper half of each word, y in the lower half
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_mem[write_slot_reg] <= {smp.accel_x_mg, smp.accel_y_mg};
        end
        if (rd_en)
        begin
            rd_data_reg <= win_mem[addr_reg[SLOT_W-1:0]];
        end
    end

    nsg_divider #(
        .DVD_W (SUM_W),
        .DVS_W (FILL_W),
        .QUO_W (QUO_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (fill),
        .done     (div_done),
        .quotient (div_quotient)
    );

    nsg_swing_lane u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .sample (rd_x),
        .mean   (mean_x_reg),
        .band   (deadband_reg),
        .count  (x_count)
    );

    nsg_swing_lane u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .sample (rd_y),
        .mean   (mean_y_reg),
        .band   (deadband_reg),
        .count  (y_count)
    );

    assign res.motion_state = motion_reg;
    assign res.x_crossings  = res_x_reg;
    assign res.y_crossings  = res_y_reg;

endmodule

`default_nettype wire

[rtl/nsg_divider.sv]
// Iterative restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none

module nsg_divider #(
    parameter int DVD_W = 18,
    parameter int DVS_W = 5,
    parameter int QUO_W = 12
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [DVD_W-1:0] dividend,
    input  wire logic        [DVS_W-1:0] divisor,
    output logic                         done,
    output logic signed      [QUO_W:0]   quotient
);
    localparam int REM_W = DVS_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [REM_W-1:0]    dvs_reg, dvs_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic                neg_reg, neg_next;

    logic [DVD_W-1:0]    mag;
    logic                fits;
    logic signed [QUO_W:0] q_pos;

    assign mag   = dividend[DVD_W-1] ? unsigned'(-dividend) : unsigned'(dividend);
    assign fits  = (rem_reg >= dvs_reg);
    assign q_pos = {1'b0, quo_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUO_W - 1);
            rem_next  = REM_W'(mag);
            dvs_next  = REM_W'(divisor) << (QUO_W - 1);
            quo_next  = '0;
            neg_next  = dividend[DVD_W-1];
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dvs_reg;
            end
            quo_next = {quo_reg[QUO_W-2:0], fits};
            dvs_next = dvs_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -q_pos : q_pos;

endmodule

`default_nettype wire

[rtl/nsg_swing_lane.sv]
// One axis lane: counts sign changes of the deviation that lie outside the deadband.
`timescale 1ns / 1ps
`default_nettype none

module nsg_swing_lane (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire nsg_pkg::lane_ctl_t                     ctl,
    input  wire logic signed [nsg_pkg::ACC_W-1:0]       sample,
    input  wire logic signed [nsg_pkg::QUO_W:0]         mean,
    input  wire logic        [nsg_pkg::DEADBAND_W-1:0]  band,
    output logic             [nsg_pkg::CROSS_W-1:0]     count
);
    import nsg_pkg::*;

    localparam int DEV_W = QUO_W + 2;

    logic signed [DEV_W-1:0] dev;
    logic signed [DEV_W-1:0] band_s;
    logic                    pos;
    logic                    neg;

    logic                    seen_reg, seen_next;
    logic                    last_neg_reg, last_neg_next;
    logic [CROSS_W-1:0]      count_reg, count_next;

    assign dev    = DEV_W'(sample) - DEV_W'(mean);
    assign band_s = signed'(DEV_W'(band));
    assign pos    = (dev > band_s);
    assign neg    = (dev < -band_s);

    always_comb
    begin
        seen_next     = seen_reg;
        last_neg_next = last_neg_reg;
        count_next    = count_reg;
        if (ctl.clear)
        begin
            seen_next     = 1'b0;
            last_neg_next = 1'b0;
            count_next    = '0;
        end
        else if (ctl.step && (pos || neg))
        begin
            // A swing is a side opposite to the last side seen.
            if (seen_reg && (neg != last_neg_reg))
            begin
                count_next = count_reg + 1'b1;
            end
            seen_next     = 1'b1;
            last_neg_next = neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            last_neg_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            seen_reg     <= seen_next;
            last_neg_reg <= last_neg_next;
            count_reg    <= count_next;
        end
    end

    assign count = count_reg;

endmodule

`default_nettype wire

[rtl/nsg_checker.sv]
// Port-level checks of the gesture detector's handshakes, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module nsg_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic smp_valid,
    input wire logic smp_ready,
    input wire logic res_valid,
    input wire logic res_ready
);

    // The block never takes a new item while a result is still on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(smp_ready && res_valid))
        else $error("sample channel ready while a result is pending");

    // An accepted item keeps the sample channel closed on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (smp_valid && smp_ready) |=> !smp_ready)
        else $error("sample channel still ready after an accept");

    // Once a result is taken the block returns to idle straight away.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> (smp_ready && !res_valid))
        else $error("block not idle after a result was taken");

    // A stalled result stays on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result withdrawn while stalled");

endmodule

bind nod_shake_gesture_detector_core nsg_checker u_nsg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp.valid),
    .smp_ready (smp.ready),
    .res_valid (res.valid),
    .res_ready (res.ready)
);

`default_nettype wire

[tb/sv/nod_shake_gesture_detector_core_tb.sv]
// Self-checking testbench of the nod and shake gesture detector core.
`timescale 1ns / 1ps

module nod_shake_gesture_detector_core_tb;
    import nsg_pkg::*;

    localparam int WIN_DEPTH = 20;

    typedef struct {
        motion_t            motion;
        logic [CROSS_W-1:0] x_cross;
        logic [CROSS_W-1:0] y_cross;
    } gesture_verdict_t;

    // Tracks the detector's window, hold deadline and registers, and keeps the
    // verdicts still owed by the block in arrival order.
    class gesture_scoreboard;
        logic [DEADBAND_W-1:0] deadband;
        logic [THRESH_W-1:0]   threshold;
        logic [HOLD_W-1:0]     hold_ticks;
        logic [MIN_FILL_W-1:0] min_fill;
        int                    x_win[WIN_DEPTH];
        int                    y_win[WIN_DEPTH];
        int unsigned           slot;
        bit                    full;
        logic [TICK_W-1:0]     deadline;
        motion_t               motion;
        gesture_verdict_t      owed_q[$];
        int                    errors;

        function new();
            deadband   = DEADBAND_RST;
            threshold  = THRESHOLD_RST;
            hold_ticks = HOLD_RST;
            min_fill   = MIN_FILL_RST;
            slot       = 0;
            full       = 1'b0;
            deadline   = '0;
            motion     = MOTION_STATIONARY;
            errors     = 0;
            foreach (x_win[i])
            begin
                x_win[i] = 0;
                y_win[i] = 0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_DEADBAND:  deadband   = val[DEADBAND_W-1:0];
                REG_THRESHOLD: threshold  = val[THRESH_W-1:0];
                REG_HOLD:      hold_ticks = val[HOLD_W-1:0];
                REG_MIN_FILL:  min_fill   = val[MIN_FILL_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Sign changes of the deviation from the mean, outside the deadband,
        // taken over the filled slots in physical order.
        function int unsigned count_swings(int w[WIN_DEPTH], int unsigned n);
            int          total;
            int          mean;
            int          dev;
            int          band;
            int          side;
            int          last_side;
            int unsigned swings;
            total     = 0;
            swings    = 0;
            last_side = 0;
            band      = int'(deadband);
            for (int i = 0; i < n; i++)
                total += w[i];
            mean = total / int'(n);
            for (int i = 0; i < n; i++)
            begin
                dev  = w[i] - mean;
                side = (dev > band) ? 1 : ((dev < -band) ? -1 : 0);
                if (side != 0 && last_side != 0 && side != last_side)
                    swings++;
                if (side != 0)
                    last_side = side;
            end
            return swings;
        endfunction

        function void note_sample(logic signed [ACC_W-1:0] ax, logic signed [ACC_W-1:0] ay,
                                  logic [TICK_W-1:0] stamp);
            gesture_verdict_t  v;
            int unsigned       fill;
            int unsigned       xc;
            int unsigned       yc;
            logic [TICK_W-1:0] since;
            xc = 0;
            yc = 0;
            x_win[slot] = int'(ax);
            y_win[slot] = int'(ay);
            slot++;
            if (slot >= WIN_DEPTH)
            begin
                slot = 0;
                full = 1'b1;
            end
            fill = full ? WIN_DEPTH : slot;
            if (fill >= min_fill)
            begin
                xc = count_swings(x_win, fill);
                yc = count_swings(y_win, fill);
                since = stamp - deadline;
                if (yc >= threshold && yc >= xc)
                begin
                    motion   = MOTION_NODDING;
                    deadline = stamp + hold_ticks;
                end
                else if (xc >= threshold && xc > yc)
                begin
                    motion   = MOTION_SHAKING;
                    deadline = stamp + hold_ticks;
                end
                else if (!since[TICK_W-1])
                    motion = MOTION_STATIONARY;
            end
            v.motion  = motion;
            v.x_cross = xc[CROSS_W-1:0];
            v.y_cross = yc[CROSS_W-1:0];
            owed_q.push_back(v);
        endfunction

        function void check_result(logic [MOTION_W-1:0] m, logic [CROSS_W-1:0] xc,
                                   logic [CROSS_W-1:0] yc);
            gesture_verdict_t v;
            if (owed_q.size() == 0)
            begin
                $error("result item with no sample waiting: motion_state %0d", m);
                errors++;
                return;
            end
            v = owed_q.pop_front();
            if (m !== v.motion)
            begin
                $error("motion_state: expected %0d, actual %0d", v.motion, m);
                errors++;
            end
            if (xc !== v.x_cross)
            begin
                $error("x_crossings: expected %0d, actual %0d", v.x_cross, xc);
                errors++;
            end
            if (yc !== v.y_cross)
            begin
                $error("y_crossings: expected %0d, actual %0d", v.y_cross, yc);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    nsg_smp_if smp ();
    nsg_res_if res ();

    gesture_scoreboard sb;
    int                send_idle_pct;
    int                recv_stall_pct;
    bit                hold_off;
    logic [TICK_W-1:0] stamp;

    nod_shake_gesture_detector_core #(
        .WINDOW_DEPTH (WIN_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp       (smp),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_off)
            res.ready <= 1'b0;
        else
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && smp.valid && smp.ready)
            sb.note_sample(smp.accel_x_mg, smp.accel_y_mg, smp.now_tick);
        if (rst_n && res.valid && res.ready)
            sb.check_result(res.motion_state, res.x_crossings, res.y_crossings);
    end

    task automatic send_sample(input int ax, input int ay, input logic [TICK_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            smp.valid <= 1'b0;
            @(posedge clk);
        end
        if (ax > 2047) ax = 2047;
        if (ax < -2048) ax = -2048;
        if (ay > 2047) ay = 2047;
        if (ay < -2048) ay = -2048;
        smp.valid      <= 1'b1;
        smp.accel_x_mg <= ax[ACC_W-1:0];
        smp.accel_y_mg <= ay[ACC_W-1:0];
        smp.now_tick   <= t;
        do
            @(posedge clk);
        while (!smp.ready);
    endtask

    // The enable is dropped before the task waits out its last edge, so back-to-back
    // writes never assign it twice in one time step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    // The task waits for the clock first so that an item accepted at the current edge has
    // been noted before the count of owed results is looked at.
    task automatic drain(input int settle);
        smp.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Bursts of oscillation on one or both axes, mixed with noise and quiet
    // stretches, so that gestures are found and held, then left to expire.
    task automatic run_random(input int n_items);
        int sent;
        int len;
        int kind;
        int amp;
        int half;
        int cx;
        int cy;
        int xv;
        int yv;
        int swing;
        int r;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(9);
            len  = $urandom_range(30, 6);
            amp  = $urandom_range(1800, 40);
            half = $urandom_range(3, 1);
            cx   = $urandom_range(2000) - 1000;
            cy   = $urandom_range(2000) - 1000;
            for (int k = 0; k < len && sent < n_items; k++)
            begin
                xv    = cx + $urandom_range(60) - 30;
                yv    = cy + $urandom_range(60) - 30;
                swing = ((k / half) % 2) ? amp : -amp;
                case (kind)
                    0, 1, 2: yv += swing;
                    3, 4, 5: xv += swing;
                    6:
                    begin
                        xv += swing;
                        yv -= swing;
                    end
                    7:
                    begin
                        xv = $urandom_range(4095) - 2048;
                        yv = $urandom_range(4095) - 2048;
                    end
                    8: ;
                    default:
                    begin
                        xv = $urandom_range(1) ? 2047 : -2048;
                        yv = $urandom_range(1) ? 2047 : -2048;
                    end
                endcase
                r = $urandom_range(99);
                if (r < 85)
                    stamp = stamp + $urandom_range(400, 1);
                else if (r < 95)
                    stamp = stamp + $urandom_range(70000, 1000);
                else if (r < 98)
                    stamp = $urandom();
                else
                    stamp = 32'hFFFF_FFFF - $urandom_range(3000);
                send_sample(xv, yv, stamp);
                sent++;
            end
        end
    endtask

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        sb             = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        smp.valid      = 1'b0;
        smp.accel_x_mg = '0;
        smp.accel_y_mg = '0;
        smp.now_tick   = '0;
        res.ready      = 1'b0;
        hold_off       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stamp          = 32'h0000_4000;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes while the window is still filling.
        send_sample(-2048, 2047, 32'h0000_0000);
        send_sample(2047, -2048, 32'hFFFF_FFFF);
        send_sample(0, 0, 32'h0000_0001);
        send_sample(-1, 1, 32'h0000_0002);
        // Nodding on y, then shaking on x with the hold deadline across the tick wrap.
        for (int k = 0; k < 8; k++)
            send_sample((k % 2) ? 20 : -20, (k % 2) ? 700 : -700, 32'd100 + k * 10);
        for (int k = 0; k < 10; k++)
            send_sample((k % 2) ? 1500 : -1500, 0, 32'hFFFF_FF00 + k * 40);
        // Quiet samples once the hold has run out.
        for (int k = 0; k < 3; k++)
            send_sample(5, 5, 32'h0000_2000 + k);

        drain(4);
        run_random(300);

        drain(4);
        cfg_write(REG_DEADBAND, 16'd0);
        cfg_write(REG_THRESHOLD, 16'd1);
        cfg_write(REG_HOLD, 16'd0);
        cfg_write(REG_MIN_FILL, 16'd1);
        send_idle_pct = 62;
        run_random(300);

        // Upper bits of the deadband write fall away at its width; the rest fit.
        drain(4);
        cfg_write(REG_DEADBAND, 16'hFFFF);
        cfg_write(REG_THRESHOLD, 16'd63);
        cfg_write(REG_HOLD, 16'hFFFF);
        cfg_write(REG_MIN_FILL, 16'd20);
        send_idle_pct  = 0;
        recv_stall_pct = 62;
        run_random(300);

        // A zero threshold and a zero minimum fill, both reached by masking.
        drain(4);
        cfg_write(REG_DEADBAND, 16'd30);
        cfg_write(REG_THRESHOLD, 16'h0040);
        cfg_write(REG_HOLD, 16'd300);
        cfg_write(REG_MIN_FILL, 16'h0080);
        send_idle_pct  = 34;
        recv_stall_pct = 34;
        run_random(300);

        // Minimum fill beyond the window: classification never runs. The
        // receiver holds off for a long stretch while samples keep coming.
        drain(4);
        cfg_write(REG_DEADBAND, 16'd100);
        cfg_write(REG_THRESHOLD, 16'd3);
        cfg_write(REG_HOLD, 16'd2000);
        cfg_write(REG_MIN_FILL, 16'd64);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            run_random(300);
        join

        for (int p = 0; p < 2; p++)
        begin
            drain(4);
            cfg_write(REG_DEADBAND, CFG_DATA_W'($urandom_range(300)));
            cfg_write(REG_THRESHOLD, CFG_DATA_W'($urandom_range(8, 1)));
            cfg_write(REG_HOLD, CFG_DATA_W'($urandom()));
            cfg_write(REG_MIN_FILL, CFG_DATA_W'($urandom_range(20, 1)));
            send_idle_pct  = $urandom_range(1) ? 62 : 0;
            recv_stall_pct = $urandom_range(1) ? 62 : 0;
            run_random(165);
        end

        drain(80);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
